>>> sv/spsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsb_pkg: shared types and constants
// Request and result layouts, status and function codes, register indexes
// and the packet type to class mapping of the strict-priority port.
// ----------------------------------------------------------------------------
package spsb_pkg;

  // Field widths fixed by the request and result layouts
  localparam int TAG_W  = 16;
  localparam int CLS_W  = 2;
  localparam int CAP_W  = 7;
  localparam int CFG_W  = 7;
  localparam int CFGI_W = 1;

  // Default sizing handed to the top level
  localparam int DEF_QUEUE_SLOTS = 64;
  localparam int DEF_TAG_BITS    = 16;
  localparam int DEF_CLASS_COUNT = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Register indexes
  localparam logic [CFGI_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFGI_W-1:0] CFG_LAST_HOP = 1'b1;

  // Packet types
  localparam logic [1:0] PT_AUDIO = 2'd0;
  localparam logic [1:0] PT_VIDEO = 2'd1;
  localparam logic [1:0] PT_DATA  = 2'd2;
  localparam logic [1:0] PT_REF   = 2'd3;

  // Classes, highest priority first
  localparam logic [CLS_W-1:0] CLS_RT   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_VID  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_BULK = 2'd2;

  typedef enum logic {
    FUNC_ARRIVAL  = 1'b0,
    FUNC_COMPLETE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_DROP   = 2'd1,
    ST_DEPART = 2'd2,
    ST_IDLE   = 2'd3
  } status_t;

  typedef struct packed {
    func_t            func;
    logic [1:0]       pkt_type;
    logic             is_ref;
    logic [TAG_W-1:0] pkt_tag;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [CLS_W-1:0] drop_class;
    logic [TAG_W-1:0] dep_tag;
    logic [CLS_W-1:0] dep_class;
    logic             ref_forward;
    logic             ref_delivered;
    logic             svc_started;
    logic [TAG_W-1:0] svc_tag;
    logic [CLS_W-1:0] svc_class;
  } out_item_t;

  // Map a packet type onto its priority class
  function automatic logic [CLS_W-1:0] pkt_class(input logic [1:0] pt);
    logic [CLS_W-1:0] c;
    unique case (pt)
      PT_VIDEO: c = CLS_VID;
      PT_DATA:  c = CLS_BULK;
      PT_AUDIO,
      PT_REF:   c = CLS_RT;
      default:  c = CLS_RT;
    endcase
    return c;
  endfunction

endpackage

>>> sv/spsb_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsb_chan_if: valid/ready channel
// Carries one request or result per handshake between source and sink.
// ----------------------------------------------------------------------------
interface spsb_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/spsb_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsb_in_reg: request input register
// Captures one request and holds it until the scheduler consumes it.
// ----------------------------------------------------------------------------
module spsb_in_reg
  import spsb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     item_vld,
  output in_item_t item,
  input  logic     take
);

  logic     vld_r, vld_nxt;
  in_item_t item_r;

  // Accept when empty or when the held request leaves this cycle
  assign in_ready = !vld_r || take;
  assign vld_nxt  = (in_valid && in_ready) || (vld_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

>>> sv/spsb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsb_store: class queue storage
// One write port and one registered read port over all class queues.
// ----------------------------------------------------------------------------
module spsb_store #(
  parameter int DEPTH = 192,
  parameter int ENT_W = 17
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [ENT_W-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [ENT_W-1:0]         rd_data
);

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_data_r;

  // Write the tail entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Fetch the entry behind the new head
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/spsb_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsb_sched: queue bookkeeping and strict-priority pick
// Tracks pointers, counts and the server, caches the first two entries of
// every class, and registers one result per request.
// ----------------------------------------------------------------------------
module spsb_sched
  import spsb_pkg::*;
#(
  parameter int QUEUE_SLOTS = DEF_QUEUE_SLOTS,
  parameter int TAG_BITS    = DEF_TAG_BITS,
  parameter int CLASS_COUNT = DEF_CLASS_COUNT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_vld,
  input  in_item_t          item,
  output logic              take,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int STORE_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int ENT_W   = STORE_W + 1;
  localparam int DEPTH   = CLASS_COUNT * QUEUE_SLOTS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PTR_W   = $clog2(QUEUE_SLOTS);
  localparam int CNT_W   = $clog2(QUEUE_SLOTS + 1);
  localparam int CLS_IW  = $clog2(CLASS_COUNT);

  // Configuration
  logic [CAP_W-1:0] cap_r;
  logic             last_hop_r;

  // Queue state
  logic [PTR_W-1:0]  head_r [CLASS_COUNT], head_nxt [CLASS_COUNT];
  logic [PTR_W-1:0]  tail_r [CLASS_COUNT], tail_nxt [CLASS_COUNT];
  logic [CNT_W-1:0]  cnt_r  [CLASS_COUNT], cnt_nxt  [CLASS_COUNT];
  logic [ENT_W-1:0]  hd_r   [CLASS_COUNT], hd_nxt   [CLASS_COUNT];
  logic [ENT_W-1:0]  nx_r   [CLASS_COUNT], nx_nxt   [CLASS_COUNT];
  logic [ENT_W-1:0]  nx_eff [CLASS_COUNT];
  logic [CAP_W-1:0]  held_r, held_nxt;
  logic              busy_r, busy_nxt;
  logic [CLS_IW-1:0] srv_r, srv_nxt;
  logic              pend_r, pend_nxt;
  logic [CLS_IW-1:0] pend_cls_r, pend_cls_nxt;

  // Result register
  logic      out_vld_r, out_vld_nxt;
  out_item_t res_r, res_nxt;

  // Storage port
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [ENT_W-1:0]  wr_data, rd_data;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLS_IW-1:0] c,
                                                  input logic [PTR_W-1:0]  p);
    return ADDR_W'(ADDR_W'(c) * ADDR_W'(QUEUE_SLOTS)) + ADDR_W'(p);
  endfunction

  spsb_store #(
    .DEPTH (DEPTH),
    .ENT_W (ENT_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Second entry of a class that was just popped comes from the read port
  always_comb begin
    for (int c = 0; c < CLASS_COUNT; c++) begin
      nx_eff[c] = (pend_r && (pend_cls_r == CLS_IW'(c))) ? rd_data : nx_r[c];
    end
  end

  assign take = item_vld && (!out_vld_r || out_ready);

  // Process the held request
  always_comb begin
    logic [CLS_W-1:0]  cls;
    logic [CLS_IW-1:0] ci;
    logic [CLS_IW-1:0] pick;
    logic              found;
    logic              drop;
    logic              cmp_idle;
    logic [ENT_W-1:0]  ent;
    logic [ENT_W-1:0]  dep;
    logic              do_pick;

    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    hd_nxt       = hd_r;
    nx_nxt       = nx_eff;
    held_nxt     = held_r;
    busy_nxt     = busy_r;
    srv_nxt      = srv_r;
    pend_nxt     = 1'b0;
    pend_cls_nxt = pend_cls_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    res_nxt      = res_r;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    rd_en        = 1'b0;
    rd_addr      = '0;

    cls      = pkt_class(item.pkt_type);
    ci       = CLS_IW'(cls);
    ent      = {item.is_ref, item.pkt_tag[STORE_W-1:0]};
    drop     = (held_r >= cap_r) || (cnt_r[ci] >= CNT_W'(QUEUE_SLOTS));
    cmp_idle = !busy_r || (srv_r > CLS_IW'(CLASS_COUNT - 1)) || (cnt_r[srv_r] == '0);
    dep      = hd_r[srv_r];
    do_pick  = 1'b0;
    pick     = '0;
    found    = 1'b0;

    if (take) begin
      out_vld_nxt = 1'b1;
      res_nxt     = '0;
      priority if (item.func == FUNC_ARRIVAL) begin
        res_nxt.drop_class = cls;
        if (drop) begin
          res_nxt.status = ST_DROP;
        end else begin
          res_nxt.status = ST_ACCEPT;
          wr_en          = 1'b1;
          wr_addr        = slot_addr(ci, tail_r[ci]);
          wr_data        = ent;
          tail_nxt[ci]   = next_slot(tail_r[ci]);
          cnt_nxt[ci]    = cnt_r[ci] + 1'b1;
          held_nxt       = held_r + 1'b1;
          // Keep the first two entries of the class in flops
          if (cnt_r[ci] == '0) begin
            hd_nxt[ci] = ent;
          end else if (cnt_r[ci] == CNT_W'(1)) begin
            nx_nxt[ci] = ent;
          end
          do_pick = !busy_r;
        end
      end else if (cmp_idle) begin
        res_nxt.status = ST_IDLE;
        busy_nxt       = 1'b0;
      end else begin
        res_nxt.status        = ST_DEPART;
        res_nxt.dep_tag       = TAG_W'(dep[STORE_W-1:0]);
        res_nxt.dep_class     = CLS_W'(srv_r);
        res_nxt.ref_forward   = dep[STORE_W] && !last_hop_r;
        res_nxt.ref_delivered = dep[STORE_W] && last_hop_r;
        head_nxt[srv_r]       = next_slot(head_r[srv_r]);
        cnt_nxt[srv_r]        = cnt_r[srv_r] - 1'b1;
        if (held_r != '0) begin
          held_nxt = held_r - 1'b1;
        end
        // Advance the head cache and refill the second entry
        hd_nxt[srv_r] = nx_eff[srv_r];
        rd_en         = 1'b1;
        rd_addr       = slot_addr(srv_r, next_slot(next_slot(head_r[srv_r])));
        pend_nxt      = 1'b1;
        pend_cls_nxt  = srv_r;
        do_pick       = 1'b1;
      end

      // Strict priority: the lowest nonempty class wins
      if (do_pick) begin
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
          if (cnt_nxt[c] != '0) begin
            pick  = CLS_IW'(c);
            found = 1'b1;
          end
        end
        busy_nxt = found;
        if (found) begin
          srv_nxt             = pick;
          res_nxt.svc_started = 1'b1;
          res_nxt.svc_tag     = TAG_W'(hd_nxt[pick][STORE_W-1:0]);
          res_nxt.svc_class   = CLS_W'(pick);
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= CAP_RESET;
      last_hop_r <= 1'b0;
      for (int c = 0; c < CLASS_COUNT; c++) begin
        head_r[c] <= '0;
        tail_r[c] <= '0;
        cnt_r[c]  <= '0;
      end
      held_r    <= '0;
      busy_r    <= 1'b0;
      srv_r     <= '0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_CAPACITY) begin
        cap_r <= cfg_wdata[CAP_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_LAST_HOP) begin
        last_hop_r <= cfg_wdata[0];
      end
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      cnt_r     <= cnt_nxt;
      held_r    <= held_nxt;
      busy_r    <= busy_nxt;
      srv_r     <= srv_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    hd_r       <= hd_nxt;
    nx_r       <= nx_nxt;
    pend_cls_r <= pend_cls_nxt;
    res_r      <= res_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = res_r;

endmodule

>>> sv/strict_priority_shared_buffer_port_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_shared_buffer_port_core: strict-priority output port
// Three class queues under one shared capacity with tail drop; one request
// is an arrival or a service completion and yields one result.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_ch   | sink      | valid/ready         | func, pkt_type, is_ref, pkt_tag
//  out_ch  | source    | valid/ready         | status, classes, tags, flags
//  cfg_*   | sink      | cfg_we, no back-off | index 0 capacity, 1 last_hop
//
// One request per cycle sustained while the sink takes results; a request
// is accepted into the input register and its result is valid once the
// result register has loaded it.
// The pick reads only the two cached entries of each class; the storage
// read port refills the second entry in the cycle after a departure.
// Reset clears pointers, counts, the server and both valid flags; storage
// is not cleared. A stalled result holds both registers; in_ready drops if a request is held.
// ----------------------------------------------------------------------------
module strict_priority_shared_buffer_port_core
  import spsb_pkg::*;
#(
  parameter int QUEUE_SLOTS = DEF_QUEUE_SLOTS,
  parameter int TAG_BITS    = DEF_TAG_BITS,
  parameter int CLASS_COUNT = DEF_CLASS_COUNT
) (
  input  logic              clk,
  input  logic              rst_n,
  spsb_chan_if.sink         in_ch,
  spsb_chan_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  logic      item_vld;
  in_item_t  item;
  logic      take;
  out_item_t res;

  // Hold the incoming request
  spsb_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (in_ch.data),
    .item_vld (item_vld),
    .item     (item),
    .take     (take)
  );

  // Queue, pick and register the result
  spsb_sched #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .TAG_BITS    (TAG_BITS),
    .CLASS_COUNT (CLASS_COUNT)
  ) u_sched (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (item_vld),
    .item      (item),
    .take      (take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  assign out_ch.data = res;

endmodule
